@@ rtl/touch_frame_translator_defines.svh @@
// Assertion macros used by the touch frame translator top level.
`ifndef TOUCH_FRAME_TRANSLATOR_DEFINES_SVH
`define TOUCH_FRAME_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("touch_frame_translator: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("touch_frame_translator: next-cycle check failed");

`endif

@@ rtl/tft_pkg.sv @@
// Types, constants and helper functions for the touch frame translator.
`default_nettype none

package tft_pkg;

	// Frame and packet geometry
	localparam int FRAME_BYTES       = 4;
	localparam int HOST_PACKET_BYTES = 6;
	localparam int DROP_COUNT        = FRAME_BYTES + 2;
	localparam int CNT_W             = $clog2(DROP_COUNT + 1);
	localparam int FIDX_W            = $clog2(FRAME_BYTES);
	localparam int BEAT_W            = $clog2(HOST_PACKET_BYTES);

	// Command queue between front and back
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

	// Q2.14 scaling
	localparam int GAIN_W    = 16;
	localparam int FRAC_BITS = 14;
	localparam int PROD_W    = 8 + GAIN_W;
	localparam int SCALED_W  = PROD_W - FRAC_BITS;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Screen protocol bytes
	localparam logic [7:0] SOT_TOUCH   = 8'hFE;
	localparam logic [7:0] SOT_UNTOUCH = 8'hFD;
	localparam logic [7:0] SOT_SIZE    = 8'hF4;
	localparam logic [7:0] EOT         = 8'hFF;
	localparam logic [7:0] SIZE_REQ    = 8'h37;

	// Host packet bytes
	localparam logic [7:0] HB_X_HI  = 8'hC0;
	localparam logic [7:0] HB_X_LO  = 8'h80;
	localparam logic [7:0] HB_Y_HI  = 8'h40;
	localparam logic [7:0] HB_ZERO  = 8'h00;
	localparam logic [7:0] HB_TRAIL = 8'h0F;

	// Register reset values
	localparam logic [7:0]        RST_Y_FRAME_HEIGHT = 8'd94;
	localparam logic [GAIN_W-1:0] RST_X_GAIN         = 16'd31130;
	localparam logic [GAIN_W-1:0] RST_Y_GAIN         = 16'd28672;
	localparam logic [7:0]        RST_COMM_LIMIT     = 8'd30;
	localparam logic [7:0]        RST_INIT_LIMIT     = 8'd36;

	// Input item kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_Y_FRAME_HEIGHT = 3'd0,
		REG_X_GAIN         = 3'd1,
		REG_Y_GAIN         = 3'd2,
		REG_COMM_LIMIT     = 3'd3,
		REG_INIT_LIMIT     = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		DEST_STATUS = 2'd0,
		DEST_HOST   = 2'd1,
		DEST_SCREEN = 2'd2
	} dest_t;

	typedef enum logic [1:0] {
		CMD_STATUS,
		CMD_SCREEN,
		CMD_TOUCH,
		CMD_UNTOUCH
	} cmd_op_t;

	// One classified item handed from front to back
	typedef struct packed {
		cmd_op_t    op;
		logic       link_ok;
		logic       init_req;
		logic [7:0] x_raw;
		logic [7:0] y_raw;
	} cmd_t;

	typedef struct packed {
		logic [7:0]        y_frame_height;
		logic [GAIN_W-1:0] x_gain;
		logic [GAIN_W-1:0] y_gain;
		logic [7:0]        comm_check_limit;
		logic [7:0]        init_check_limit;
	} cfg_t;

	// Drop the fraction of a Q2.14 product and clamp to one byte
	function automatic logic [7:0] sat_scale(input logic [PROD_W-1:0] p);
		logic [SCALED_W-1:0] q;
		q = p[PROD_W-1:FRAC_BITS];
		if (|q[SCALED_W-1:8])
			return 8'hFF;
		return q[7:0];
	endfunction

	// Host packet byte at a given beat
	function automatic logic [7:0] pkt_byte(input cmd_op_t op, input logic [BEAT_W-1:0] idx,
		input logic [7:0] x, input logic [7:0] y);
		logic [7:0] b;
		b = HB_ZERO;
		if (op == CMD_TOUCH) begin
			case (idx)
				BEAT_W'(0): b = HB_X_HI | {6'd0, x[7:6]};
				BEAT_W'(1): b = HB_X_LO | {2'd0, x[5:0]};
				BEAT_W'(2): b = HB_Y_HI | {6'd0, y[7:6]};
				BEAT_W'(3): b = {2'd0, y[5:0]};
				BEAT_W'(5): b = HB_TRAIL;
				default:    b = HB_ZERO;
			endcase
		end else begin
			case (idx)
				BEAT_W'(0): b = HB_X_HI;
				BEAT_W'(1): b = HB_X_LO;
				BEAT_W'(2): b = HB_Y_HI;
				default:    b = HB_ZERO;
			endcase
		end
		return b;
	endfunction

endpackage

`default_nettype wire

@@ rtl/touch_frame_translator.sv @@
// Top level of the touch frame translator: registers, front, queue and back.
//
// Input channel: push/full carries one item per beat, either a screen byte
// (kind 0, rx_byte) or a one-second tick (kind 1). Items are taken every
// cycle while full is low. Result channel: while empty is low the oldest
// result is on dest/out_byte/last/link_ok/init_request; pop takes it.
// Each screen byte or tick yields one result, except a completed touch or
// untouch frame, which yields six host bytes with last on the sixth.
// Path: an item is written into the command queue, then the scale stage,
// then the output register. Throughput: one result per cycle while the
// receiver pops, set by the single output register fed by the packet sequencer; a
// six-byte host packet holds the sequencer until its last byte while the front
// end keeps taking items into a four-entry command queue.
// When the receiver stalls, the output register holds, the sequencer
// waits, the queue fills and full rises; nothing is lost.
// Reset: capture, counters and link status clear, registers return to
// their defaults; the frame store is not cleared and needs no clearing.
// Configuration: cfg_valid/cfg_ready writes register cfg_index with
// cfg_data; cfg_ready is always high. Write only while the block is idle.
`default_nettype none
`include "touch_frame_translator_defines.svh"

module touch_frame_translator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// item input
	input  wire logic                           push,
	output logic                                full,
	input  wire logic                           kind,
	input  wire logic [7:0]                     rx_byte,
	// results
	output logic                                empty,
	input  wire logic                           pop,
	output logic [1:0]                          dest,
	output logic [7:0]                          out_byte,
	output logic                                last,
	output logic                                link_ok,
	output logic                                init_request,
	// configuration writes
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tft_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tft_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tft_pkg::*;

	cfg_t cfg_q;
	cmd_t front_cmd;
	cmd_t queue_cmd;
	logic accept;
	logic queue_empty;
	logic queue_pop;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.y_frame_height   <= RST_Y_FRAME_HEIGHT;
			cfg_q.x_gain           <= RST_X_GAIN;
			cfg_q.y_gain           <= RST_Y_GAIN;
			cfg_q.comm_check_limit <= RST_COMM_LIMIT;
			cfg_q.init_check_limit <= RST_INIT_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_Y_FRAME_HEIGHT: cfg_q.y_frame_height   <= cfg_data[7:0];
				REG_X_GAIN:         cfg_q.x_gain           <= cfg_data[GAIN_W-1:0];
				REG_Y_GAIN:         cfg_q.y_gain           <= cfg_data[GAIN_W-1:0];
				REG_COMM_LIMIT:     cfg_q.comm_check_limit <= cfg_data[7:0];
				REG_INIT_LIMIT:     cfg_q.init_check_limit <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	tft_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.kind    (kind),
		.rx_byte (rx_byte),
		.cfg     (cfg_q),
		.cmd     (front_cmd)
	);

	tft_cmd_fifo u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (front_cmd),
		.full   (full),
		.pop    (queue_pop),
		.rdata  (queue_cmd),
		.empty  (queue_empty)
	);

	tft_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_rdata    (queue_cmd),
		.cmd_empty    (queue_empty),
		.cmd_pop      (queue_pop),
		.cfg          (cfg_q),
		.pop          (pop),
		.empty        (empty),
		.dest         (dest),
		.out_byte     (out_byte),
		.last         (last),
		.link_ok      (link_ok),
		.init_request (init_request)
	);

	// Only host packets have beats that are not the last
	`TFT_ASSERT_NOW(a_nonlast_is_host, clk, arst_n, !empty && !last, dest == DEST_HOST)
	// Init requests ride only on single-beat results
	`TFT_ASSERT_NOW(a_init_single, clk, arst_n, !empty && init_request,
		last && (dest != DEST_HOST))
	// A packet beat taken mid-packet is followed at once by the next host beat
	`TFT_ASSERT_NEXT(a_packet_gapless, clk, arst_n, !empty && pop && !last,
		!empty && (dest == DEST_HOST))

endmodule

`default_nettype wire

@@ rtl/tft_front.sv @@
// Front end: frame capture, heartbeat counters and item classification.
`default_nettype none

module tft_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic          kind,
	input  wire logic [7:0]    rx_byte,
	input  wire tft_pkg::cfg_t cfg,
	output tft_pkg::cmd_t      cmd
);
	import tft_pkg::*;

	logic             capturing_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       store_q [FRAME_BYTES];
	logic             link_good_q;
	logic [7:0]       comm_q;
	logic [7:0]       init_q;

	logic             is_start;
	logic             take;
	logic [CNT_W-1:0] count_inc;
	logic             frame_done;
	logic             frame_drop;
	logic             init_fire;
	logic             comm_fire;
	logic [7:0]       head;

	// Classify the presented item against the current state
	always_comb begin
		is_start   = (rx_byte == SOT_TOUCH) || (rx_byte == SOT_UNTOUCH) ||
			(rx_byte == SOT_SIZE);
		take       = (kind == KIND_BYTE) && (capturing_q || is_start);
		count_inc  = count_q + CNT_W'(1);
		// byte count is nonzero only while capturing, so the end byte is this one
		frame_done = take && (count_q == CNT_W'(FRAME_BYTES - 1)) && (rx_byte == EOT);
		frame_drop = take && (count_inc >= CNT_W'(DROP_COUNT));
		head       = store_q[0];
		init_fire  = !link_good_q && (init_q > cfg.init_check_limit);
		comm_fire  = (comm_q > cfg.comm_check_limit) && !capturing_q;

		cmd.op       = CMD_STATUS;
		cmd.link_ok  = link_good_q;
		cmd.init_req = 1'b0;
		cmd.x_raw    = store_q[1];
		cmd.y_raw    = cfg.y_frame_height - store_q[2];
		if (kind == KIND_TICK) begin
			cmd.init_req = init_fire;
			if (comm_fire) begin
				cmd.op      = CMD_SCREEN;
				cmd.link_ok = 1'b0;
			end
		end else if (frame_done) begin
			if (head == SOT_TOUCH)
				cmd.op = CMD_TOUCH;
			else if (head == SOT_UNTOUCH)
				cmd.op = CMD_UNTOUCH;
			else if (head == SOT_SIZE)
				cmd.link_ok = 1'b1;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capturing_q <= 1'b0;
			count_q     <= '0;
			link_good_q <= 1'b0;
			comm_q      <= '0;
			init_q      <= '0;
		end else if (accept) begin
			if (kind == KIND_TICK) begin
				if (!link_good_q)
					init_q <= init_fire ? 8'd0 : init_q + 8'd1;
				comm_q <= comm_fire ? 8'd0 : comm_q + 8'd1;
				if (comm_fire)
					link_good_q <= 1'b0;
			end else if (frame_done) begin
				capturing_q <= 1'b0;
				count_q     <= '0;
				if (head == SOT_SIZE) begin
					link_good_q <= 1'b1;
					init_q      <= '0;
				end
			end else if (frame_drop) begin
				capturing_q <= 1'b0;
				count_q     <= '0;
			end else if (take) begin
				capturing_q <= 1'b1;
				count_q     <= count_inc;
			end
		end
	end

	// Frame bytes; bytes past the frame length are not kept
	always_ff @(posedge clk) begin
		if (accept && take && (count_q < CNT_W'(FRAME_BYTES)))
			store_q[count_q[FIDX_W-1:0]] <= rx_byte;
	end

endmodule

`default_nettype wire

@@ rtl/tft_cmd_fifo.sv @@
// Short command queue between the front end and the packet generator.
`default_nettype none

module tft_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire tft_pkg::cmd_t wdata,
	output logic               full,
	input  wire logic          pop,
	output tft_pkg::cmd_t      rdata,
	output logic               empty
);
	import tft_pkg::*;

	cmd_t                 mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_PTR_W:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	always_comb begin
		full    = (count_q == (CMD_PTR_W + 1)'(CMD_DEPTH));
		empty   = (count_q == '0);
		do_push = push && !full;
		do_pop  = pop && !empty;
		rdata   = mem_q[rd_ptr_q];
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (CMD_PTR_W + 1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (CMD_PTR_W + 1)'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

`default_nettype wire

@@ rtl/tft_back.sv @@
// Back end: coordinate scaling and result sequencing into the output register.
`default_nettype none

module tft_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tft_pkg::cmd_t cmd_rdata,
	input  wire logic          cmd_empty,
	output logic               cmd_pop,
	input  wire tft_pkg::cfg_t cfg,
	input  wire logic          pop,
	output logic               empty,
	output logic [1:0]         dest,
	output logic [7:0]         out_byte,
	output logic               last,
	output logic               link_ok,
	output logic               init_request
);
	import tft_pkg::*;

	// Scale stage
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [PROD_W-1:0] xprod_s1;
	logic [PROD_W-1:0] yprod_s1;
	logic [BEAT_W-1:0] beat_q;

	// Output register
	logic       out_valid_q;
	dest_t      dest_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       link_q;
	logic       init_q;

	logic       out_ready;
	logic       is_pkt;
	logic       beat_last;
	logic       gen_fire;
	logic       load_s1;
	logic [7:0] x_sat;
	logic [7:0] y_sat;
	dest_t      gen_dest;
	logic [7:0] gen_byte;

	// Beat generation
	always_comb begin
		out_ready = !out_valid_q || pop;
		is_pkt    = (cmd_s1.op == CMD_TOUCH) || (cmd_s1.op == CMD_UNTOUCH);
		beat_last = !is_pkt || (beat_q == BEAT_W'(HOST_PACKET_BYTES - 1));
		gen_fire  = valid_s1 && out_ready;
		load_s1   = !cmd_empty && (!valid_s1 || (gen_fire && beat_last));
		cmd_pop   = load_s1;
		x_sat     = sat_scale(xprod_s1);
		y_sat     = sat_scale(yprod_s1);

		unique case (cmd_s1.op) inside
			CMD_STATUS: begin
				gen_dest = DEST_STATUS;
				gen_byte = HB_ZERO;
			end
			CMD_SCREEN: begin
				gen_dest = DEST_SCREEN;
				gen_byte = SIZE_REQ;
			end
			CMD_TOUCH, CMD_UNTOUCH: begin
				gen_dest = DEST_HOST;
				gen_byte = pkt_byte(cmd_s1.op, beat_q, x_sat, y_sat);
			end
			default: begin
				gen_dest = DEST_STATUS;
				gen_byte = HB_ZERO;
			end
		endcase
	end

	// Stage and beat control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			beat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1)
				valid_s1 <= 1'b1;
			else if (gen_fire && beat_last)
				valid_s1 <= 1'b0;
			if (gen_fire)
				beat_q <= beat_last ? '0 : beat_q + BEAT_W'(1);
			if (out_ready)
				out_valid_q <= gen_fire;
		end
	end

	// Payload: command and gain products, then the result beat
	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1   <= cmd_rdata;
			xprod_s1 <= PROD_W'(cmd_rdata.x_raw) * PROD_W'(cfg.x_gain);
			yprod_s1 <= PROD_W'(cmd_rdata.y_raw) * PROD_W'(cfg.y_gain);
		end
		if (gen_fire) begin
			dest_q <= gen_dest;
			byte_q <= gen_byte;
			last_q <= beat_last;
			link_q <= cmd_s1.link_ok;
			init_q <= cmd_s1.init_req;
		end
	end

	assign empty        = !out_valid_q;
	assign dest         = dest_q;
	assign out_byte     = byte_q;
	assign last         = last_q;
	assign link_ok      = link_q;
	assign init_request = init_q;

endmodule

`default_nettype wire

@@ dv/tb_touch_frame_translator.sv @@
// Self-checking testbench for the touch frame translator: random and directed traffic.
`default_nettype none

module tb_touch_frame_translator;
	timeunit 1ns;
	timeprecision 1ps;

	import tft_pkg::*;

	localparam int HOLD_CYCLES = 200;

	typedef struct {
		logic       kind;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct {
		dest_t      dest;
		logic [7:0] out_byte;
		logic       last;
		logic       link_ok;
		logic       init_request;
	} result_t;

	// Clock, reset and block ports
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic kind = KIND_BYTE;
	logic [7:0] rx_byte = 8'h00;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic full, empty, last, link_ok, init_request, cfg_ready;
	logic [1:0] dest;
	logic [7:0] out_byte;

	// Stimulus and scoreboard state
	in_item_t pending_items[$];
	result_t due_results[$];
	int items_queued = 0;
	int items_accepted = 0;
	int cfg_writes_seen = 0;
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic in_taken = 1'b0;
	logic hold_armed = 1'b0;
	int hold_count = 0;
	logic hold_active;

	// Predicted block state and register copy
	logic [7:0]  y_height_m = RST_Y_FRAME_HEIGHT;
	logic [15:0] x_gain_m = RST_X_GAIN;
	logic [15:0] y_gain_m = RST_Y_GAIN;
	logic [7:0]  comm_limit_m = RST_COMM_LIMIT;
	logic [7:0]  init_limit_m = RST_INIT_LIMIT;
	logic        capturing_m = 1'b0;
	logic [2:0]  frame_len_m = '0;
	logic [7:0]  frame_m [FRAME_BYTES] = '{default: 8'h00};
	logic        link_good_m = 1'b0;
	logic [7:0]  comm_ticks_m = '0;
	logic [7:0]  init_ticks_m = '0;

	touch_frame_translator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.dest         (dest),
		.out_byte     (out_byte),
		.last         (last),
		.link_ok      (link_ok),
		.init_request (init_request),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 200)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	// Q2.14 gain: drop the fraction, clamp to a byte
	function automatic logic [7:0] scale_coord(input logic [7:0] v, input logic [15:0] gain);
		logic [23:0] prod;
		prod = 24'(v) * 24'(gain);
		if (prod[23:22] != 2'b00)
			return 8'hFF;
		return prod[21:14];
	endfunction

	function automatic void expect_result(input dest_t d, input logic [7:0] b, input logic lst,
		input logic ireq);
		result_t r;
		r.dest = d;
		r.out_byte = b;
		r.last = lst;
		r.link_ok = link_good_m;
		r.init_request = ireq;
		due_results.push_back(r);
	endfunction

	// Advance the predicted state by one accepted item and queue its results
	function automatic void translate_item(input in_item_t it);
		logic ireq;
		logic send;
		logic [7:0] old, yf, xs, ys;
		logic [7:0] pkt [HOST_PACKET_BYTES];
		ireq = 1'b0;
		send = 1'b0;
		if (it.kind == KIND_TICK) begin
			// init heartbeat only runs while the link is down
			if (!link_good_m) begin
				old = init_ticks_m;
				init_ticks_m = init_ticks_m + 8'd1;
				if (old > init_limit_m) begin
					init_ticks_m = '0;
					ireq = 1'b1;
				end
			end
			old = comm_ticks_m;
			comm_ticks_m = comm_ticks_m + 8'd1;
			if (old > comm_limit_m && !capturing_m) begin
				comm_ticks_m = '0;
				link_good_m = 1'b0;
				expect_result(DEST_SCREEN, SIZE_REQ, 1'b1, ireq);
			end else begin
				expect_result(DEST_STATUS, HB_ZERO, 1'b1, ireq);
			end
			return;
		end

		// capture: start bytes open a frame, everything is taken once open
		if (capturing_m || it.rx_byte == SOT_TOUCH || it.rx_byte == SOT_UNTOUCH ||
				it.rx_byte == SOT_SIZE) begin
			capturing_m = 1'b1;
			if (frame_len_m < 3'(FRAME_BYTES))
				frame_m[frame_len_m[FIDX_W-1:0]] = it.rx_byte;
			frame_len_m = frame_len_m + 3'd1;
		end

		if (frame_len_m == 3'(FRAME_BYTES) && frame_m[FRAME_BYTES-1] == EOT) begin
			frame_len_m = '0;
			capturing_m = 1'b0;
			if (frame_m[0] == SOT_TOUCH) begin
				yf = y_height_m - frame_m[2];
				xs = scale_coord(frame_m[1], x_gain_m);
				ys = scale_coord(yf, y_gain_m);
				pkt[0] = HB_X_HI | {6'd0, xs[7:6]};
				pkt[1] = HB_X_LO | {2'd0, xs[5:0]};
				pkt[2] = HB_Y_HI | {6'd0, ys[7:6]};
				pkt[3] = {2'd0, ys[5:0]};
				pkt[4] = HB_ZERO;
				pkt[5] = HB_TRAIL;
				send = 1'b1;
			end else if (frame_m[0] == SOT_UNTOUCH) begin
				pkt[0] = HB_X_HI;
				pkt[1] = HB_X_LO;
				pkt[2] = HB_Y_HI;
				pkt[3] = HB_ZERO;
				pkt[4] = HB_ZERO;
				pkt[5] = HB_ZERO;
				send = 1'b1;
			end else if (frame_m[0] == SOT_SIZE) begin
				link_good_m = 1'b1;
				init_ticks_m = '0;
			end
			if (send) begin
				for (int k = 0; k < HOST_PACKET_BYTES; k++)
					expect_result(DEST_HOST, pkt[k], k == HOST_PACKET_BYTES - 1, 1'b0);
				return;
			end
		end else if (frame_len_m >= 3'(DROP_COUNT)) begin
			// no valid end within the allowed bytes: drop the capture
			frame_len_m = '0;
			capturing_m = 1'b0;
		end
		expect_result(DEST_STATUS, HB_ZERO, 1'b1, 1'b0);
	endfunction

	// Monitor: input beats, register writes and result checks
	always @(posedge clk) begin : monitor
		in_item_t taken;
		result_t want;
		in_taken = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_Y_FRAME_HEIGHT: y_height_m = cfg_data[7:0];
					REG_X_GAIN:         x_gain_m = cfg_data;
					REG_Y_GAIN:         y_gain_m = cfg_data;
					REG_COMM_LIMIT:     comm_limit_m = cfg_data[7:0];
					REG_INIT_LIMIT:     init_limit_m = cfg_data[7:0];
					default: ;
				endcase
				cfg_writes_seen++;
			end
			if (push && !full) begin
				in_taken = 1'b1;
				taken.kind = kind;
				taken.rx_byte = rx_byte;
				translate_item(taken);
				items_accepted++;
			end
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					report_mismatch($sformatf("result dest=%0d byte=%02h with nothing expected",
						dest, out_byte));
				end else begin
					want = due_results.pop_front();
					if (dest !== want.dest)
						report_mismatch($sformatf("dest got %0d want %0d", dest, want.dest));
					if (out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte got %02h want %02h",
							out_byte, want.out_byte));
					if (last !== want.last)
						report_mismatch($sformatf("last got %b want %b", last, want.last));
					if (link_ok !== want.link_ok)
						report_mismatch($sformatf("link_ok got %b want %b",
							link_ok, want.link_ok));
					if (init_request !== want.init_request)
						report_mismatch($sformatf("init_request got %b want %b",
							init_request, want.init_request));
				end
			end
		end
	end

	// Sender: offers the next pending item once the previous beat is taken
	always @(negedge clk) begin : sender
		in_item_t next;
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || in_taken) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next = pending_items.pop_front();
				push <= 1'b1;
				kind <= next.kind;
				rx_byte <= next.rx_byte;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted here
	assign hold_active = hold_armed && hold_count < HOLD_CYCLES;

	always @(negedge clk) begin : hold_off
		if (hold_active)
			hold_count <= hold_count + 1;
	end

	// Receiver: random pops, none during the hold-off
	always @(negedge clk) begin : receiver
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic void add_item(input logic k, input logic [7:0] b);
		in_item_t it;
		it.kind = k;
		it.rx_byte = b;
		pending_items.push_back(it);
		items_queued++;
	endfunction

	// Frame byte, sometimes preceded by a tick landing mid-capture
	function automatic void add_frame_byte(input logic [7:0] b);
		if ($urandom_range(99) < 8)
			add_item(KIND_TICK, 8'($urandom_range(255)));
		add_item(KIND_BYTE, b);
	endfunction

	function automatic logic [7:0] pick_start();
		case ($urandom_range(2))
			0: return SOT_TOUCH;
			1: return SOT_UNTOUCH;
			default: return SOT_SIZE;
		endcase
	endfunction

	// Mostly well-formed frames, plus ticks, broken frames and noise
	function automatic void add_random_items(input int target);
		int first, r, n;
		logic [7:0] head;
		first = items_queued;
		while (items_queued - first < target) begin
			r = $urandom_range(99);
			if (r < 55) begin
				head = (r < 30) ? SOT_TOUCH : (r < 45) ? SOT_UNTOUCH : SOT_SIZE;
				add_frame_byte(head);
				add_frame_byte(8'($urandom_range(255)));
				add_frame_byte(8'($urandom_range(255)));
				add_frame_byte(EOT);
			end else if (r < 70) begin
				add_item(KIND_TICK, 8'($urandom_range(255)));
			end else if (r < 82) begin
				n = $urandom_range(1, 5);
				add_frame_byte(pick_start());
				repeat (n) add_frame_byte(8'($urandom_range(255)));
			end else begin
				add_item(KIND_BYTE, 8'($urandom_range(255)));
			end
		end
	endfunction

	task automatic write_register(input reg_idx_t idx, input logic [15:0] value);
		int seen;
		seen = cfg_writes_seen;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(negedge clk); while (cfg_writes_seen == seen);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(input logic [7:0] height, input logic [15:0] xg,
		input logic [15:0] yg, input logic [7:0] comm_lim, input logic [7:0] init_lim);
		write_register(REG_Y_FRAME_HEIGHT, {8'd0, height});
		write_register(REG_X_GAIN, xg);
		write_register(REG_Y_GAIN, yg);
		write_register(REG_COMM_LIMIT, {8'd0, comm_lim});
		write_register(REG_INIT_LIMIT, {8'd0, init_lim});
	endtask

	// Every queued item taken and every result back
	task automatic wait_drained();
		do @(negedge clk);
		while (items_accepted != items_queued || due_results.size() != 0);
	endtask

	initial begin : stimulus
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Sender idles lightly, receiver heavily
		send_idle_pct = 33;
		recv_idle_pct = 77;

		// Directed: touch at both coordinate extremes (x saturates, y flip wraps)
		add_item(KIND_BYTE, SOT_TOUCH);
		add_item(KIND_BYTE, 8'h00);
		add_item(KIND_BYTE, 8'h00);
		add_item(KIND_BYTE, EOT);
		add_item(KIND_BYTE, SOT_TOUCH);
		add_item(KIND_BYTE, 8'hFF);
		add_item(KIND_BYTE, 8'hFF);
		add_item(KIND_BYTE, EOT);
		// untouch and frame size report
		add_item(KIND_BYTE, SOT_UNTOUCH);
		add_item(KIND_BYTE, 8'h12);
		add_item(KIND_BYTE, 8'h34);
		add_item(KIND_BYTE, EOT);
		add_item(KIND_BYTE, SOT_SIZE);
		add_item(KIND_BYTE, 8'h00);
		add_item(KIND_BYTE, 8'h00);
		add_item(KIND_BYTE, EOT);
		// start bytes as data, bad end byte, capture dropped
		add_item(KIND_BYTE, SOT_TOUCH);
		add_item(KIND_BYTE, SOT_TOUCH);
		add_item(KIND_BYTE, SOT_UNTOUCH);
		add_item(KIND_BYTE, SOT_SIZE);
		add_item(KIND_BYTE, 8'h00);
		add_item(KIND_BYTE, 8'h01);
		// idle noise byte and ticks
		add_item(KIND_BYTE, 8'h00);
		add_item(KIND_TICK, 8'hFF);
		add_item(KIND_TICK, 8'h00);
		wait_drained();

		// Zero height, zero x gain, full y gain and zero limits: heartbeat and init fire as soon as their counts pass zero
		apply_settings(8'd0, 16'd0, 16'hFFFF, 8'd0, 8'd0);
		add_random_items(60);
		wait_drained();

		// Sender idles heavily, receiver lightly; top values but zero y gain
		send_idle_pct = 77;
		recv_idle_pct = 33;
		apply_settings(8'd255, 16'hFFFF, 16'd0, 8'd255, 8'd255);
		add_random_items(60);
		wait_drained();

		// No idling, random settings with low limits, receiver holds off to back up the block
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_settings(8'($urandom_range(255)), 16'($urandom_range(65535)),
			16'($urandom_range(65535)), 8'($urandom_range(2, 8)), 8'($urandom_range(2, 10)));
		add_random_items(60);
		hold_armed = 1'b1;
		wait_drained();

		// Catch stray results after the last expected one
		repeat (10) @(negedge clk);
		if (due_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", due_results.size()));
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#1_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire

@@ touch_frame_translator.f @@
+incdir+rtl
rtl/tft_pkg.sv
rtl/tft_front.sv
rtl/tft_cmd_fifo.sv
rtl/tft_back.sv
rtl/touch_frame_translator.sv
dv/tb_touch_frame_translator.sv
